// ===== hdl/dfs_adjacency_matrix_walker_core_macros.svh =====
// Assertion macros used by the walker datapath.
// Each macro checks a clocked implication with an asynchronous active-low reset.
`ifndef DFS_ADJACENCY_MATRIX_WALKER_CORE_MACROS_SVH
`define DFS_ADJACENCY_MATRIX_WALKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define DFSAM_ASSERT_IMPL(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("walker assertion failed");

`define DFSAM_ASSERT_NEXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("walker assertion failed");

`else

`define DFSAM_ASSERT_IMPL(name, clock, rst_n, ante, cons)

`define DFSAM_ASSERT_NEXT(name, clock, rst_n, ante, cons)

`endif

`endif

// ===== hdl/dfsam_pkg.sv =====
`timescale 1ns / 1ps

package dfsam_pkg;

	localparam int OPCODE_W = 2;
	localparam int LABEL_W = 8;
	localparam int INDEX_W = 4;

	// Edge endpoints are four bits wide, so no edge ever touches a vertex at or
	// above this index.
	localparam int INDEX_LIMIT = 16;

	localparam logic [OPCODE_W-1:0] OP_ADD_VERTEX = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_ADD_EDGE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_RUN = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic add_vertex;
		logic add_edge;
		logic start_run;
		logic step;
	} ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic found;
		logic stack_one;
		logic out_busy;
		logic total_zero;
	} status_t;

endpackage

// ===== hdl/dfsam_cmd_if.sv =====
`timescale 1ns / 1ps

interface dfsam_cmd_if;
	import dfsam_pkg::*;

	logic valid;
	logic ready;
	logic [OPCODE_W-1:0] opcode;
	logic [LABEL_W-1:0] label;
	logic [INDEX_W-1:0] edge_from;
	logic [INDEX_W-1:0] edge_to;

	modport source(output valid, output opcode, output label, output edge_from,
		output edge_to, input ready);
	modport sink(input valid, input opcode, input label, input edge_from,
		input edge_to, output ready);

endinterface

// ===== hdl/dfsam_visit_if.sv =====
`timescale 1ns / 1ps

interface dfsam_visit_if;
	import dfsam_pkg::*;

	logic valid;
	logic ready;
	logic [INDEX_W-1:0] vertex_index;
	logic [LABEL_W-1:0] vertex_label;
	logic last;

	modport source(output valid, output vertex_index, output vertex_label,
		output last, input ready);
	modport sink(input valid, input vertex_index, input vertex_label,
		input last, output ready);

endinterface

// ===== hdl/dfs_adjacency_matrix_walker_core.sv =====
// Add-vertex and add-edge beats are accepted back to back.
// After a run beat is accepted, the walk makes one step (a visit or a pop) per cycle
// while the output is not stalled; the single step unit sets that rate.
// No command beat is accepted while a walk is in progress; a stalled output holds the walk.
// Reset clears the adjacency matrix, vertex count, visited flags and stack depth at once;
// labels and stack entries are undefined until written, and no clearing pass is needed.
`timescale 1ns / 1ps

module dfs_adjacency_matrix_walker_core #(
	parameter int MAX_VERTICES = 16
) (
	input logic clk,
	input logic arst_n,
	dfsam_cmd_if.sink cmd,
	dfsam_visit_if.source visit
);
	import dfsam_pkg::*;

	// The controller owns the handshake on the command channel and sequences the
	// walk; the datapath holds the graph, the stack and the output register.
	ctl_t ctl;
	status_t status;

	dfsam_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.valid(cmd.valid),
		.opcode(cmd.opcode),
		.ready(cmd.ready),
		.status(status),
		.ctl(ctl)
	);

	// Each step looks up the lowest unvisited neighbour of the vertex on top of the
	// stack. The vertex found in one step is held until a later step finds a successor or
	// ends the walk and shows whether it was the final one, so the last flag is exact.
	dfsam_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.label(cmd.label),
		.edge_from(cmd.edge_from),
		.edge_to(cmd.edge_to),
		.ctl(ctl),
		.status(status),
		.visit_ready(visit.ready),
		.visit_valid(visit.valid),
		.vertex_index(visit.vertex_index),
		.vertex_label(visit.vertex_label),
		.last(visit.last)
	);

endmodule

// ===== hdl/dfsam_ctrl.sv =====
`timescale 1ns / 1ps

module dfsam_ctrl (
	input logic clk,
	input logic arst_n,
	input logic valid,
	input logic [dfsam_pkg::OPCODE_W-1:0] opcode,
	output logic ready,
	input dfsam_pkg::status_t status,
	output dfsam_pkg::ctl_t ctl
);
	import dfsam_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	state_t state_q;
	logic accept;

	always_comb begin
		ready = (state_q == ST_IDLE);
		accept = valid && ready;
		ctl.add_vertex = accept && (opcode == OP_ADD_VERTEX);
		ctl.add_edge = accept && (opcode == OP_ADD_EDGE);
		ctl.start_run = accept && (opcode == OP_RUN) && !status.total_zero;
		ctl.step = (state_q == ST_WALK) && !status.out_busy;
	end

	// The walk ends when the bottom entry of the stack has no neighbour left.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctl.start_run) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (ctl.step && !status.found && status.stack_one) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/dfsam_dp.sv =====
`timescale 1ns / 1ps
`include "dfs_adjacency_matrix_walker_core_macros.svh"

module dfsam_dp #(
	parameter int MAX_VERTICES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic [dfsam_pkg::LABEL_W-1:0] label,
	input logic [dfsam_pkg::INDEX_W-1:0] edge_from,
	input logic [dfsam_pkg::INDEX_W-1:0] edge_to,
	input dfsam_pkg::ctl_t ctl,
	output dfsam_pkg::status_t status,
	input logic visit_ready,
	output logic visit_valid,
	output logic [dfsam_pkg::INDEX_W-1:0] vertex_index,
	output logic [dfsam_pkg::LABEL_W-1:0] vertex_label,
	output logic last
);
	import dfsam_pkg::*;

	// Only vertices below ADJ_N can carry edges, so only they can be reached.
	localparam int ADJ_N = (MAX_VERTICES < INDEX_LIMIT) ? MAX_VERTICES : INDEX_LIMIT;
	localparam int VW = $clog2(ADJ_N);
	localparam int TW = $clog2(MAX_VERTICES + 1);
	localparam int DW = $clog2(ADJ_N + 1);

	logic [ADJ_N-1:0] adj_q [ADJ_N];
	logic [LABEL_W-1:0] label_q [ADJ_N];
	logic [VW-1:0] stack_q [ADJ_N];
	logic [TW-1:0] total_q;
	logic [ADJ_N-1:0] visited_q;
	logic [DW-1:0] depth_q;
	logic [VW-1:0] pending_q;
	logic visit_valid_q;
	logic [INDEX_W-1:0] vertex_index_q;
	logic [LABEL_W-1:0] vertex_label_q;
	logic last_q;

	logic [DW-1:0] depth_m1;
	logic [VW-1:0] top_vtx;
	logic [ADJ_N-1:0] limit_mask;
	logic [ADJ_N-1:0] cand;
	logic found;
	logic [VW-1:0] next_vtx;
	logic stack_one;
	logic emit;
	logic edge_ok;
	logic [VW-1:0] idx_a;
	logic [VW-1:0] idx_b;

	always_comb begin
		depth_m1 = depth_q - DW'(1);
		top_vtx = stack_q[depth_m1[VW-1:0]];
		for (int i = 0; i < ADJ_N; i++) begin
			limit_mask[i] = (TW'(i) < total_q);
		end
		cand = adj_q[top_vtx] & ~visited_q & limit_mask;
		found = |cand;
		next_vtx = '0;
		for (int i = ADJ_N - 1; i >= 0; i--) begin
			if (cand[i]) begin
				next_vtx = VW'(i);
			end
		end
		stack_one = (depth_q == DW'(1));
		// The held vertex leaves when a successor is found or the walk ends.
		emit = ctl.step && (found || stack_one);
		edge_ok = ({1'b0, edge_from} < (INDEX_W + 1)'(ADJ_N))
			&& ({1'b0, edge_to} < (INDEX_W + 1)'(ADJ_N));
		idx_a = edge_from[VW-1:0];
		idx_b = edge_to[VW-1:0];

		status.found = found;
		status.stack_one = stack_one;
		status.out_busy = visit_valid_q && !visit_ready;
		status.total_zero = (total_q == '0);

		visit_valid = visit_valid_q;
		vertex_index = vertex_index_q;
		vertex_label = vertex_label_q;
		last = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ADJ_N; r++) begin
				adj_q[r] <= '0;
			end
			total_q <= '0;
			visited_q <= '0;
			depth_q <= '0;
			visit_valid_q <= 1'b0;
		end else begin
			if (ctl.add_vertex && (total_q < TW'(MAX_VERTICES))) begin
				total_q <= total_q + TW'(1);
			end
			if (ctl.add_edge && edge_ok) begin
				adj_q[idx_a][idx_b] <= 1'b1;
				adj_q[idx_b][idx_a] <= 1'b1;
			end
			if (ctl.start_run) begin
				visited_q <= ADJ_N'(1);
				depth_q <= DW'(1);
			end
			if (ctl.step) begin
				if (found) begin
					visited_q[next_vtx] <= 1'b1;
					if (depth_q < DW'(ADJ_N)) begin
						depth_q <= depth_q + DW'(1);
					end
				end else begin
					depth_q <= depth_m1;
					if (stack_one) begin
						visited_q <= '0;
					end
				end
			end
			if (emit) begin
				visit_valid_q <= 1'b1;
			end else if (visit_ready) begin
				visit_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add_vertex && (total_q < TW'(ADJ_N))) begin
			label_q[total_q[VW-1:0]] <= label;
		end
		if (ctl.start_run) begin
			stack_q[0] <= '0;
			pending_q <= '0;
		end
		if (ctl.step && found) begin
			if (depth_q < DW'(ADJ_N)) begin
				stack_q[depth_q[VW-1:0]] <= next_vtx;
			end
			pending_q <= next_vtx;
		end
		if (emit) begin
			vertex_index_q <= INDEX_W'(pending_q);
			vertex_label_q <= label_q[pending_q];
			last_q <= !found;
		end
	end

	`DFSAM_ASSERT_IMPL(a_depth_bound, clk, arst_n, 1'b1, depth_q <= DW'(ADJ_N))
	`DFSAM_ASSERT_IMPL(a_no_overwrite, clk, arst_n, emit, !(visit_valid_q && !visit_ready))
	`DFSAM_ASSERT_NEXT(a_visited_cleared, clk, arst_n, emit && !found, visited_q == '0)
	`DFSAM_ASSERT_IMPL(a_root_visited, clk, arst_n, visited_q != '0, visited_q[0])

endmodule
